[sv/mpcs_pkg.sv]
`timescale 1ns / 1ps
// shared constants, command codes and control structs of the motion color stats block
// no dependencies

package mpcs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 32;

    localparam int PIX_W     = 8;
    localparam int FIELD_CRD = 12;
    localparam int FRAME_W   = 13;
    localparam int CNT_OUT_W = 32;
    localparam int FIX_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [PIX_W-1:0]   THRESHOLD_RST = 8'd50;
    localparam logic [FRAME_W-1:0] WIDTH_RST     = 13'd640;
    localparam logic [FRAME_W-1:0] HEIGHT_RST    = 13'd480;

    // datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_MUL_DEN   = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_P1    = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_P2    = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_STEP  = 4'd4;
    localparam logic [OP_W-1:0] OP_SAVE_DEN  = 4'd5;
    localparam logic [OP_W-1:0] OP_SAVE_P1   = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV_MEAN  = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_VAR   = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd9;
    localparam logic [OP_W-1:0] OP_SAVE_MEAN = 4'd10;
    localparam logic [OP_W-1:0] OP_SQRT_LOAD = 4'd11;
    localparam logic [OP_W-1:0] OP_SQRT_STEP = 4'd12;
    localparam logic [OP_W-1:0] OP_SAVE_DEV  = 4'd13;
    localparam logic [OP_W-1:0] OP_OUT_LOAD  = 4'd14;

    typedef struct packed {
        logic            accept;
        logic [OP_W-1:0] op;
        logic [1:0]      ch;
    } mpcs_cmd_t;

    typedef struct packed {
        logic snap;
        logic out_free;
        logic n_zero;
        logic n_lt2;
        logic p1_le_p2;
    } mpcs_stat_t;

endpackage

[sv/mpcs_if.sv]
`timescale 1ns / 1ps
// channel interfaces: pixel pair input, statistics result, configuration writes
// depends on mpcs_pkg

interface mpcs_pix_if import mpcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     cur_red;
    logic [PIX_W-1:0]     cur_green;
    logic [PIX_W-1:0]     cur_blue;
    logic [PIX_W-1:0]     next_red;
    logic [PIX_W-1:0]     next_green;
    logic [PIX_W-1:0]     next_blue;
    logic [FIELD_CRD-1:0] col;
    logic [FIELD_CRD-1:0] row;
    logic                 last;

    modport source (output valid, cur_red, cur_green, cur_blue, next_red, next_green,
                    next_blue, col, row, last, input ready);
    modport sink (input valid, cur_red, cur_green, cur_blue, next_red, next_green,
                  next_blue, col, row, last, output ready);
endinterface

interface mpcs_res_if import mpcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CNT_OUT_W-1:0] motion_count;
    logic [FIX_W-1:0]     mean_red;
    logic [FIX_W-1:0]     mean_green;
    logic [FIX_W-1:0]     mean_blue;
    logic [FIX_W-1:0]     dev_red;
    logic [FIX_W-1:0]     dev_green;
    logic [FIX_W-1:0]     dev_blue;
    logic [FIELD_CRD-1:0] box_left;
    logic [FIELD_CRD-1:0] box_right;
    logic [FIELD_CRD-1:0] box_top;
    logic [FIELD_CRD-1:0] box_bottom;

    modport source (output valid, motion_count, mean_red, mean_green, mean_blue, dev_red,
                    dev_green, dev_blue, box_left, box_right, box_top, box_bottom,
                    input ready);
    modport sink (input valid, motion_count, mean_red, mean_green, mean_blue, dev_red,
                  dev_green, dev_blue, box_left, box_right, box_top, box_bottom,
                  output ready);
endinterface

interface mpcs_cfg_if import mpcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/mpcs_ctrl.sv]
`timescale 1ns / 1ps
// controller: accumulate phase, then sequences multiply, divide and root per channel
// depends on mpcs_pkg

module mpcs_ctrl import mpcs_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  mpcs_stat_t stat,
    output mpcs_cmd_t  cmd
);

    localparam int MUL_STEPS  = (COUNT_BITS + 8 + 7) / 8;
    localparam int MEAN_STEPS = 16;
    localparam int VAR_STEPS  = 32;
    localparam int ROOT_STEPS = 16;
    localparam int CW         = 5;

    localparam logic [4:0] S_ACC      = 5'd0;
    localparam logic [4:0] S_DEN_LD   = 5'd1;
    localparam logic [4:0] S_DEN_RUN  = 5'd2;
    localparam logic [4:0] S_DEN_SAVE = 5'd3;
    localparam logic [4:0] S_CH       = 5'd4;
    localparam logic [4:0] S_MEAN_RUN = 5'd5;
    localparam logic [4:0] S_MEAN_SV  = 5'd6;
    localparam logic [4:0] S_P1_RUN   = 5'd7;
    localparam logic [4:0] S_P1_SAVE  = 5'd8;
    localparam logic [4:0] S_P2_RUN   = 5'd9;
    localparam logic [4:0] S_P2_CHK   = 5'd10;
    localparam logic [4:0] S_VAR_RUN  = 5'd11;
    localparam logic [4:0] S_SQ_LD    = 5'd12;
    localparam logic [4:0] S_SQ_RUN   = 5'd13;
    localparam logic [4:0] S_DEV_SAVE = 5'd14;
    localparam logic [4:0] S_OUT      = 5'd15;

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    ch_reg, ch_next;
    logic [4:0]    after_ch;

    assign after_ch = (ch_reg == 2'd2) ? S_OUT : S_CH;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        cmd.accept = 1'b0;
        cmd.op     = OP_NONE;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.accept = 1'b1;
                if (stat.snap)
                begin
                    state_next = S_DEN_LD;
                    ch_next    = 2'd0;
                end
            end
            S_DEN_LD:
            begin
                cmd.op     = OP_MUL_DEN;
                cnt_next   = CW'(MUL_STEPS - 1);
                state_next = S_DEN_RUN;
            end
            S_DEN_RUN:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_DEN_SAVE;
            end
            S_DEN_SAVE:
            begin
                cmd.op     = OP_SAVE_DEN;
                state_next = S_CH;
            end
            S_CH:
            begin
                // no moving pixel: mean and deviation stay cleared
                if (stat.n_zero)
                begin
                    state_next = after_ch;
                    ch_next    = ch_reg + 1'b1;
                end
                else
                begin
                    cmd.op     = OP_DIV_MEAN;
                    cnt_next   = CW'(MEAN_STEPS - 1);
                    state_next = S_MEAN_RUN;
                end
            end
            S_MEAN_RUN:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_MEAN_SV;
            end
            S_MEAN_SV:
            begin
                cmd.op = OP_SAVE_MEAN;
                if (stat.n_lt2)
                begin
                    state_next = after_ch;
                    ch_next    = ch_reg + 1'b1;
                end
                else
                begin
                    state_next = S_P1_RUN;
                    cnt_next   = CW'(MUL_STEPS);
                end
            end
            S_P1_RUN:
            begin
                // loads the multiplier first, then the steps follow
                cmd.op   = (cnt_reg == CW'(MUL_STEPS)) ? OP_MUL_P1 : OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_P1_SAVE;
            end
            S_P1_SAVE:
            begin
                cmd.op     = OP_SAVE_P1;
                cnt_next   = CW'(MUL_STEPS);
                state_next = S_P2_RUN;
            end
            S_P2_RUN:
            begin
                cmd.op   = (cnt_reg == CW'(MUL_STEPS)) ? OP_MUL_P2 : OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_P2_CHK;
            end
            S_P2_CHK:
            begin
                if (stat.p1_le_p2)
                begin
                    state_next = after_ch;
                    ch_next    = ch_reg + 1'b1;
                end
                else
                begin
                    cmd.op     = OP_DIV_VAR;
                    cnt_next   = CW'(VAR_STEPS - 1);
                    state_next = S_VAR_RUN;
                end
            end
            S_VAR_RUN:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_SQ_LD;
            end
            S_SQ_LD:
            begin
                cmd.op     = OP_SQRT_LOAD;
                cnt_next   = CW'(ROOT_STEPS - 1);
                state_next = S_SQ_RUN;
            end
            S_SQ_RUN:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_DEV_SAVE;
            end
            S_DEV_SAVE:
            begin
                cmd.op     = OP_SAVE_DEV;
                state_next = after_ch;
                ch_next    = ch_reg + 1'b1;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            cnt_reg   <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

[sv/mpcs_dp.sv]
`timescale 1ns / 1ps
// datapath: accumulators, snapshot, sequential multiplier, divider and root, result register
// depends on mpcs_pkg and the channel interfaces

module mpcs_dp import mpcs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  mpcs_cmd_t   cmd,
    output mpcs_stat_t  stat,
    mpcs_pix_if.sink    pix,
    mpcs_res_if.source  stats,
    mpcs_cfg_if.sink    cfg
);

    localparam int C   = COUNT_BITS;
    localparam int S1W = C + 8;
    localparam int S2W = C + 16;
    localparam int PW  = 2 * C + 24;
    localparam int DW  = 2 * C;
    localparam int RW  = 2 * C + 1;
    localparam int MDW = C + 17;
    localparam int XW  = COORD_BITS + FIELD_CRD;
    localparam int FXW = COORD_BITS + FRAME_W;
    localparam int OXW = C + CNT_OUT_W;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    function automatic logic [COORD_BITS-1:0] centre_of(input logic [FRAME_W-1:0] size);
        logic [FXW-1:0] half;
        half = FXW'(size >> 1);
        if (half > FXW'(COORD_MAX))
            return COORD_MAX;
        return half[COORD_BITS-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // configuration
    logic [PIX_W-1:0]   thr_reg;
    logic [FRAME_W-1:0] fw_reg, fh_reg;

    // running accumulators
    logic [C-1:0]          tally_reg;
    logic [S1W-1:0]        s1_reg [3];
    logic [S2W-1:0]        s2_reg [3];
    logic [COORD_BITS-1:0] cmin_reg, cmax_reg, rmin_reg, rmax_reg;

    // values after the current pixel
    logic [C-1:0]          tally_a;
    logic [S1W-1:0]        s1_a [3];
    logic [S2W-1:0]        s2_a [3];
    logic [COORD_BITS-1:0] cmin_a, cmax_a, rmin_a, rmax_a;
    logic [PIX_W-1:0]      nxt [3];
    logic                  moving, counting, fire;
    logic [COORD_BITS-1:0] pc, pr;

    // frozen copy of the finished sequence
    logic [C-1:0]          n_snap;
    logic [S1W-1:0]        s1_snap [3];
    logic [S2W-1:0]        s2_snap [3];
    logic [COORD_BITS-1:0] cmin_snap, cmax_snap, rmin_snap, rmax_snap;
    logic [FIX_W-1:0]      mean_reg [3];
    logic [FIX_W-1:0]      dev_reg [3];

    // shared arithmetic units
    logic [PW-1:0]    ma_reg, acc_reg, p1_reg;
    logic [S1W-1:0]   mb_reg;
    logic [PW+7:0]    part;
    logic [DW-1:0]    den_reg, div_reg;
    logic [RW-1:0]    r_reg;
    logic [31:0]      q_reg, sq_reg;
    logic [RW:0]      rt;
    logic             ge;
    logic [MDW-1:0]   mdiv;
    logic [PW-1:0]    num;
    logic [FIX_W-1:0] d_reg, bit_reg, cand;
    logic [31:0]      csq;
    logic [S1W-1:0]   s1_sel;
    logic [S2W-1:0]   s2_sel;
    logic [OXW-1:0]   n_wide;

    logic out_valid_reg;

    assign fire      = pix.valid & pix.ready;
    assign pix.ready = cmd.accept;
    assign cfg.ready = 1'b1;

    assign nxt[0] = pix.next_red;
    assign nxt[1] = pix.next_green;
    assign nxt[2] = pix.next_blue;
    assign pc     = COORD_BITS'(XW'(pix.col));
    assign pr     = COORD_BITS'(XW'(pix.row));

    assign moving = (absdiff(pix.cur_red, pix.next_red) > thr_reg)
                 && (absdiff(pix.cur_green, pix.next_green) > thr_reg)
                 && (absdiff(pix.cur_blue, pix.next_blue) > thr_reg);
    assign counting = moving && (tally_reg != '1);

    always_comb
    begin
        tally_a = counting ? tally_reg + 1'b1 : tally_reg;
        for (int i = 0; i < 3; i++)
        begin
            s1_a[i] = counting ? s1_reg[i] + S1W'(nxt[i]) : s1_reg[i];
            s2_a[i] = counting ? s2_reg[i] + S2W'({8'd0, nxt[i]} * {8'd0, nxt[i]})
                               : s2_reg[i];
        end
        cmin_a = (moving && pc < cmin_reg) ? pc : cmin_reg;
        cmax_a = (moving && pc > cmax_reg) ? pc : cmax_reg;
        rmin_a = (moving && pr < rmin_reg) ? pr : rmin_reg;
        rmax_a = (moving && pr > rmax_reg) ? pr : rmax_reg;
    end

    assign s1_sel = s1_snap[cmd.ch];
    assign s2_sel = s2_snap[cmd.ch];
    assign part   = ma_reg * mb_reg[7:0];
    assign rt     = {r_reg, q_reg[31]};
    assign ge     = rt >= (RW+1)'(div_reg);
    assign mdiv   = {1'b0, s1_sel, 8'd0} + MDW'(n_snap >> 1);
    assign num    = p1_reg - acc_reg;
    assign cand   = d_reg | bit_reg;
    assign csq    = cand * cand;
    assign n_wide = OXW'(n_snap);

    assign stat.snap     = fire & pix.last;
    assign stat.out_free = !out_valid_reg || stats.ready;
    assign stat.n_zero   = (n_snap == '0);
    assign stat.n_lt2    = (n_snap < C'(2));
    assign stat.p1_le_p2 = (p1_reg <= acc_reg);

    // accumulators and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THRESHOLD_RST;
            fw_reg    <= WIDTH_RST;
            fh_reg    <= HEIGHT_RST;
            tally_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                s1_reg[i] <= '0;
                s2_reg[i] <= '0;
            end
            cmin_reg <= centre_of(WIDTH_RST);
            cmax_reg <= centre_of(WIDTH_RST);
            rmin_reg <= centre_of(HEIGHT_RST);
            rmax_reg <= centre_of(HEIGHT_RST);
        end
        else
        begin
            if (fire && pix.last)
            begin
                tally_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    s1_reg[i] <= '0;
                    s2_reg[i] <= '0;
                end
                cmin_reg <= centre_of(fw_reg);
                cmax_reg <= centre_of(fw_reg);
                rmin_reg <= centre_of(fh_reg);
                rmax_reg <= centre_of(fh_reg);
            end
            else if (fire)
            begin
                tally_reg <= tally_a;
                s1_reg    <= s1_a;
                s2_reg    <= s2_a;
                cmin_reg  <= cmin_a;
                cmax_reg  <= cmax_a;
                rmin_reg  <= rmin_a;
                rmax_reg  <= rmax_a;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_THRESHOLD:
                    begin
                        thr_reg <= cfg.data[PIX_W-1:0];
                    end
                    REG_WIDTH:
                    begin
                        fw_reg   <= cfg.data;
                        cmin_reg <= centre_of(cfg.data);
                        cmax_reg <= centre_of(cfg.data);
                    end
                    REG_HEIGHT:
                    begin
                        fh_reg   <= cfg.data;
                        rmin_reg <= centre_of(cfg.data);
                        rmax_reg <= centre_of(cfg.data);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // snapshot and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (fire && pix.last)
        begin
            n_snap    <= tally_a;
            s1_snap   <= s1_a;
            s2_snap   <= s2_a;
            cmin_snap <= cmin_a;
            cmax_snap <= cmax_a;
            rmin_snap <= rmin_a;
            rmax_snap <= rmax_a;
            for (int i = 0; i < 3; i++)
            begin
                mean_reg[i] <= '0;
                dev_reg[i]  <= '0;
            end
        end
        case (cmd.op)
            OP_MUL_DEN:
            begin
                ma_reg  <= PW'(n_snap);
                mb_reg  <= S1W'(n_snap - 1'b1);
                acc_reg <= '0;
            end
            OP_MUL_P1:
            begin
                ma_reg  <= PW'(s2_sel);
                mb_reg  <= S1W'(n_snap);
                acc_reg <= '0;
            end
            OP_MUL_P2:
            begin
                ma_reg  <= PW'(s1_sel);
                mb_reg  <= s1_sel;
                acc_reg <= '0;
            end
            OP_MUL_STEP:
            begin
                acc_reg <= acc_reg + part[PW-1:0];
                ma_reg  <= ma_reg << 8;
                mb_reg  <= mb_reg >> 8;
            end
            OP_SAVE_DEN:
            begin
                den_reg <= acc_reg[DW-1:0];
            end
            OP_SAVE_P1:
            begin
                p1_reg <= acc_reg;
            end
            OP_DIV_MEAN:
            begin
                r_reg   <= RW'(mdiv >> 16);
                q_reg   <= {mdiv[15:0], 16'd0};
                div_reg <= DW'(n_snap);
            end
            OP_DIV_VAR:
            begin
                r_reg   <= RW'(num >> 16);
                q_reg   <= {num[15:0], 16'd0};
                div_reg <= den_reg;
            end
            OP_DIV_STEP:
            begin
                r_reg <= ge ? RW'(rt - (RW+1)'(div_reg)) : RW'(rt);
                q_reg <= {q_reg[30:0], ge};
            end
            OP_SAVE_MEAN:
            begin
                mean_reg[cmd.ch] <= q_reg[FIX_W-1:0];
            end
            OP_SQRT_LOAD:
            begin
                sq_reg  <= q_reg;
                d_reg   <= '0;
                bit_reg <= 16'h8000;
            end
            OP_SQRT_STEP:
            begin
                if (csq <= sq_reg)
                    d_reg <= cand;
                bit_reg <= bit_reg >> 1;
            end
            OP_SAVE_DEV:
            begin
                dev_reg[cmd.ch] <= d_reg;
            end
            OP_OUT_LOAD:
            begin
                stats.motion_count <= (n_wide > OXW'(32'hFFFF_FFFF)) ? '1
                                      : n_wide[CNT_OUT_W-1:0];
                stats.mean_red     <= mean_reg[0];
                stats.mean_green   <= mean_reg[1];
                stats.mean_blue    <= mean_reg[2];
                stats.dev_red      <= dev_reg[0];
                stats.dev_green    <= dev_reg[1];
                stats.dev_blue     <= dev_reg[2];
                stats.box_left     <= FIELD_CRD'(XW'(cmin_snap));
                stats.box_right    <= FIELD_CRD'(XW'(cmax_snap));
                stats.box_top      <= FIELD_CRD'(XW'(rmin_snap));
                stats.box_bottom   <= FIELD_CRD'(XW'(rmax_snap));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT_LOAD)
            out_valid_reg <= 1'b1;
        else if (stats.ready)
            out_valid_reg <= 1'b0;
    end

    assign stats.valid = out_valid_reg;

endmodule

[sv/motion_pixel_color_stats.sv]
`timescale 1ns / 1ps
// frame difference motion statistics: one pixel pair accepted per cycle while accumulating
// after the pair marked last, input stalls while one shared multiplier (8 bits per cycle),
// a radix-2 divider and a 16-step root run per channel; the result then sits in an
// output register
// reset (rst_n low, asynchronous) restores register defaults and clears the accumulators

module motion_pixel_color_stats import mpcs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    mpcs_pix_if.sink    pix,
    mpcs_res_if.source  stats,
    mpcs_cfg_if.sink    cfg
);

    // command and status between controller and datapath
    mpcs_cmd_t  cmd;
    mpcs_stat_t stat;

    // controller: accumulate state, denominator product, then per channel mean, p1, p2, variance, root
    mpcs_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: accumulators, snapshot of the closed sequence, arithmetic units
    mpcs_dp #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .pix   (pix),
        .stats (stats),
        .cfg   (cfg)
    );

    // the last pixel of a sequence closes the input until the result is built
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && pix.last) |=> !pix.ready)
        else $error("input accepted right after last transaction");

    // a result appears only through the output load command
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stats.valid) |-> $past(cmd.op == OP_OUT_LOAD))
        else $error("result valid without load");

    // a mean of 8-bit values never exceeds 255.5 in 8.8
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        stats.valid |-> (stats.mean_red <= 16'hFF80 && stats.mean_green <= 16'hFF80
                         && stats.mean_blue <= 16'hFF80))
        else $error("mean out of range");

    // no input is taken while the result computation runs
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_NONE && cmd.op != OP_OUT_LOAD) |-> !pix.ready)
        else $error("input ready during computation");

endmodule
